[rtl/utf8_stream_validator_macros.svh]
// Assertion macros shared by the validator RTL.
`ifndef UTF8_STREAM_VALIDATOR_MACROS_SVH
`define UTF8_STREAM_VALIDATOR_MACROS_SVH

`ifndef NO_ASSERTIONS

// Same-cycle implication, checked on every rising clock edge out of reset
`define UTF8SV_ASSERT_NOW(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("utf8 validator: same-cycle check failed");

// Next-cycle implication
`define UTF8SV_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("utf8 validator: next-cycle check failed");

`else

`define UTF8SV_ASSERT_NOW(label, ante, cons)
`define UTF8SV_ASSERT_NEXT(label, ante, cons)

`endif

`endif

[rtl/utf8sv_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package utf8sv_pkg;

   // Width of the saturating good-character counter (8 to 64)
   localparam int COUNT_BITS = 32;

   localparam int BYTE_W  = 8;
   localparam int CP_W    = 21;
   localparam int FIELD_W = 32;   // char_count field on the result channel

   // Byte class boundaries
   localparam logic [7:0] ASCII_MAX    = 8'h7F;
   localparam logic [7:0] BAD_LEAD_MAX = 8'hC1;
   localparam logic [7:0] LEAD2_MAX    = 8'hDF;
   localparam logic [7:0] LEAD3_MAX    = 8'hEF;
   localparam logic [7:0] LEAD4_MAX    = 8'hF4;
   localparam logic [1:0] CONT_TAG     = 2'b10;

   // Payload masks of lead bytes
   localparam logic [7:0] LEAD2_MASK = 8'h1F;
   localparam logic [7:0] LEAD3_MASK = 8'h0F;
   localparam logic [7:0] LEAD4_MASK = 8'h07;

   // Minimum-value classes of a sequence
   localparam logic [1:0] MIN_NONE = 2'd0;
   localparam logic [1:0] MIN_80   = 2'd1;
   localparam logic [1:0] MIN_800  = 2'd2;
   localparam logic [1:0] MIN_10K  = 2'd3;

   typedef struct packed {
      logic [1:0]            pending;
      logic [CP_W-1:0]       partial;
      logic [1:0]            min_class;
      logic                  error;
      logic [COUNT_BITS-1:0] count;
   } state_type;

   typedef struct packed {
      logic [CP_W-1:0]    code_point;
      logic               char_done;
      logic               error_seen;
      logic [FIELD_W-1:0] char_count;
      logic               string_end;
   } result_type;

   // Smallest legal code point for a class
   function automatic logic [CP_W-1:0] class_minimum(input logic [1:0] cls);
      logic [CP_W-1:0] m;
      unique case (cls)
         MIN_80:  m = 21'h00080;
         MIN_800: m = 21'h00800;
         MIN_10K: m = 21'h10000;
         default: m = '0;
      endcase
      return m;
   endfunction

   // Low 32 bits of the counter, zero-extended when the counter is narrower
   function automatic logic [FIELD_W-1:0] count_field(input logic [COUNT_BITS-1:0] cnt);
      logic [COUNT_BITS+FIELD_W-1:0] wide;
      wide = {{FIELD_W{1'b0}}, cnt};
      return wide[FIELD_W-1:0];
   endfunction

endpackage

`default_nettype wire

[rtl/utf8sv_decode.sv]
`timescale 1ns / 1ps
`default_nettype none

// One byte step of the decoder: current state and byte in, next state and result out.
module utf8sv_decode (
   input  utf8sv_pkg::state_type  state_cur,
   input  logic [7:0]             data_byte,
   input  logic                   last_byte,
   output utf8sv_pkg::state_type  state_nxt,
   output utf8sv_pkg::result_type result
);
   import utf8sv_pkg::*;

   state_type       st;
   logic            done;
   logic [CP_W-1:0] cp;
   logic [CP_W-1:0] shifted;

   assign shifted = {state_cur.partial[CP_W-7:0], data_byte[5:0]};

   always_comb begin
      st   = state_cur;
      done = 1'b0;
      cp   = '0;

      if (!state_cur.error) begin
         if (state_cur.pending == 2'd0) begin
            // Expecting a lead byte
            priority if (data_byte <= ASCII_MAX) begin
               done = 1'b1;
               cp   = {{(CP_W-BYTE_W){1'b0}}, data_byte};
            end else if (data_byte <= BAD_LEAD_MAX) begin
               st.error = 1'b1;
            end else if (data_byte <= LEAD2_MAX) begin
               st.pending   = 2'd1;
               st.partial   = {{(CP_W-BYTE_W){1'b0}}, data_byte & LEAD2_MASK};
               st.min_class = MIN_80;
            end else if (data_byte <= LEAD3_MAX) begin
               st.pending   = 2'd2;
               st.partial   = {{(CP_W-BYTE_W){1'b0}}, data_byte & LEAD3_MASK};
               st.min_class = MIN_800;
            end else if (data_byte <= LEAD4_MAX) begin
               st.pending   = 2'd3;
               st.partial   = {{(CP_W-BYTE_W){1'b0}}, data_byte & LEAD4_MASK};
               st.min_class = MIN_10K;
            end else begin
               st.error = 1'b1;
            end
         end else if (data_byte[7:6] != CONT_TAG) begin
            // Anything but a continuation byte breaks the sequence
            st.error = 1'b1;
         end else begin
            st.partial = shifted;
            st.pending = state_cur.pending - 2'd1;
            if (st.pending == 2'd0) begin
               // Sequence complete: overlong check
               if (shifted < class_minimum(state_cur.min_class)) begin
                  st.error = 1'b1;
               end else begin
                  done         = 1'b1;
                  cp           = shifted;
                  st.partial   = '0;
                  st.min_class = MIN_NONE;
               end
            end
         end

         // Saturating count of good characters
         if (done && (st.count != {COUNT_BITS{1'b1}})) begin
            st.count = st.count + 1'b1;
         end

         // Sequence cut off by the end of the string
         if (last_byte && (st.pending != 2'd0)) begin
            st.error = 1'b1;
         end

         if (st.error) begin
            st.pending   = 2'd0;
            st.partial   = '0;
            st.min_class = MIN_NONE;
         end
      end

      result.code_point = cp;
      result.char_done  = done;
      result.error_seen = st.error;
      result.char_count = count_field(st.count);
      result.string_end = last_byte;

      // End of string returns everything to reset
      state_nxt = last_byte ? '0 : st;
   end

endmodule

`default_nettype wire

[rtl/utf8_stream_validator.sv]
`timescale 1ns / 1ps
`default_nettype none

// Channel   Dir  Handshake              Payload
// req_*     in   req_tvalid/req_tready  tdata[7:0] data_byte, tlast last_byte
// rsp_*     out  rsp_tvalid/rsp_tready  tdata code_point, char_count; tuser flags; tlast
//
// One byte is accepted per cycle while rsp does not stall; each byte gives exactly one result transaction.
// Each byte passes an input register, then the decode step into the result register.
// The decode state loop closes through the single state register, so the rate is one byte per clock without rsp stalls.
// Stalls on rsp back up through both stages; req_tready stays high while the input stage is empty
// or its byte advances. Synchronous reset clears all decode state and both valid flags.
module utf8_stream_validator (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,    // [7:0] data_byte
   input  logic        req_tlast,    // last_byte
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [55:0] rsp_tdata,    // [20:0] code_point, [52:21] char_count, [55:53] zero
   output logic [1:0]  rsp_tuser,    // [0] char_done, [1] error_seen
   output logic        rsp_tlast     // string_end
);
   import utf8sv_pkg::*;

   `include "utf8_stream_validator_macros.svh"

   // Input stage
   logic       in_valid_ff, in_valid_in;
   logic [7:0] in_byte_ff;
   logic       in_last_ff;

   // Result stage
   logic       out_valid_ff, out_valid_in;
   result_type out_ff;

   // Decode state
   state_type  state_ff, state_in;
   result_type step_result;

   logic advance;

   assign advance     = in_valid_ff && (!out_valid_ff || rsp_tready);
   assign req_tready  = !in_valid_ff || advance;
   assign in_valid_in = (req_tvalid && req_tready) || (in_valid_ff && !advance);
   assign out_valid_in = advance || (out_valid_ff && !rsp_tready);

   utf8sv_decode u_decode (
      .state_cur (state_ff),
      .data_byte (in_byte_ff),
      .last_byte (in_last_ff),
      .state_nxt (state_in),
      .result    (step_result)
   );

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         state_ff     <= '0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         if (advance) begin
            state_ff <= state_in;
         end
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         in_byte_ff <= req_tdata;
         in_last_ff <= req_tlast;
      end
      if (advance) begin
         out_ff <= step_result;
      end
   end

   // Result channel packing
   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {3'b000, out_ff.char_count, out_ff.code_point};
   assign rsp_tuser  = {out_ff.error_seen, out_ff.char_done};
   assign rsp_tlast  = out_ff.string_end;

   // A completed character never coexists with an error verdict
   `UTF8SV_ASSERT_NOW(a_done_no_error, out_valid_ff && out_ff.char_done, !out_ff.error_seen)
   // The last byte of a string leaves the decoder in its reset state
   `UTF8SV_ASSERT_NEXT(a_end_clears, advance && in_last_ff, state_ff == '0)
   // A byte held in the input stage is not dropped while the result side stalls
   `UTF8SV_ASSERT_NEXT(a_hold_input, in_valid_ff && !advance, in_valid_ff && $stable(in_byte_ff))

endmodule

`default_nettype wire
